// ===== rtl/core/pts_pkg.sv =====
// Package for the periodic timer scheduler: field widths, op and result codes,
// sequencer states. No dependencies; used by the interfaces, core and checker.
package pts_pkg;

  localparam int HID_W            = 8;
  localparam int ARG_W            = 32;
  localparam int SEC_W            = 17;
  localparam int TIME_W           = 32;
  localparam int MAX_INTERVAL_SEC = 3600 * 24;
  localparam int MAX_RESULTS      = 16;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_REGISTER   = 2'd1,
    OP_UNREGISTER = 2'd2,
    OP_RESERVED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_FIRED        = 3'd0,
    KIND_REGISTERED   = 3'd1,
    KIND_BAD_INTERVAL = 3'd2,
    KIND_FULL         = 3'd3,
    KIND_REMOVED      = 3'd4,
    KIND_NOT_FOUND    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

endpackage

// ===== rtl/core/pts_if.sv =====
// Valid/ready channel interfaces for requests and results of the timer scheduler.
// Depends on pts_pkg.
interface pts_req_if;
  logic                              valid;
  logic                              ready;
  pts_pkg::op_t                      op;
  logic [pts_pkg::HID_W-1:0]         handler_id;
  logic signed [pts_pkg::ARG_W-1:0]  handler_arg;
  logic [pts_pkg::SEC_W-1:0]         interval_sec;

  modport source (output valid, op, handler_id, handler_arg, interval_sec, input ready);
  modport sink   (input valid, op, handler_id, handler_arg, interval_sec, output ready);
endinterface

interface pts_rsp_if;
  logic                              valid;
  logic                              ready;
  pts_pkg::kind_t                    kind;
  logic [pts_pkg::HID_W-1:0]         handler_id_res;
  logic signed [pts_pkg::ARG_W-1:0]  handler_arg_res;
  logic                              last;

  modport source (output valid, kind, handler_id_res, handler_arg_res, last, input ready);
  modport sink   (input valid, kind, handler_id_res, handler_arg_res, last, output ready);
endinterface

// ===== rtl/core/pts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/periodic_timer_scheduler_top.sv =====
// A register or unregister request gives its one result after one sweep of the entry RAM.
// A tick that fires k timers takes k+1 sweeps; every pass is one sweep of
// the entry RAM through the single compare unit, one entry per cycle.
// Throughput: one request at a time; ready only while the sequencer is idle.
// Reset (rst, synchronous): clock, insertion counter and all valid bits clear at once; entry RAM
// contents are not cleared and no clearing pass runs. Depends on pts_pkg, pts_if, pts_ram.
module periodic_timer_scheduler_top #(
  parameter int NUM_TIMERS       = 16,
  parameter int TICKS_PER_SECOND = 100
) (
  input  logic         clk,
  input  logic         rst,
  pts_req_if.sink      req,
  pts_rsp_if.source    rsp
);

  localparam int IDXW  = $clog2(NUM_TIMERS);
  localparam int CNTW  = $clog2(NUM_TIMERS + 1);
  localparam int PERW  = $clog2(pts_pkg::MAX_INTERVAL_SEC * TICKS_PER_SECOND + 1);
  localparam int FIREW = $clog2(pts_pkg::MAX_RESULTS + 1);
  localparam int TW    = pts_pkg::TIME_W;

  typedef struct packed {
    logic [pts_pkg::HID_W-1:0] handler;
    logic [pts_pkg::ARG_W-1:0] argument;
    logic [PERW-1:0]           period;
    logic [TW-1:0]             deadline;
    logic [TW-1:0]             order;
  } entry_t;

  localparam int RECW = $bits(entry_t);

  // Sequencer and request registers
  pts_pkg::state_t             state, state_next;
  pts_pkg::op_t                op_q;
  logic [pts_pkg::HID_W-1:0]   id_q;
  logic [pts_pkg::ARG_W-1:0]   arg_q;
  logic [PERW-1:0]             period_q;
  logic                        bad_q;

  // Scheduler state
  logic [TW-1:0]               now_clk;
  logic [TW-1:0]               order_cnt;
  logic [NUM_TIMERS-1:0]       vld;

  // Scan pipeline
  logic [CNTW-1:0]             scan_cnt;
  logic                        cmp_vld;
  logic [IDXW-1:0]             cmp_idx;
  logic                        match_found, free_found, best_found;
  logic [IDXW-1:0]             match_idx, free_idx, best_idx;
  entry_t                      best;
  logic [TW-1:0]               best_age;

  // Fire bookkeeping for ticks
  logic [FIREW-1:0]            fire_cnt;
  logic                        hold_vld;
  logic [pts_pkg::HID_W-1:0]   hold_id;
  logic [pts_pkg::ARG_W-1:0]   hold_arg;

  // Output register
  logic                        rsp_vld_q;
  pts_pkg::kind_t              rsp_kind_q;
  logic [pts_pkg::HID_W-1:0]   rsp_id_q;
  logic [pts_pkg::ARG_W-1:0]   rsp_arg_q;
  logic                        rsp_last_q;

  // Control from the output block
  logic                        accept;
  logic                        out_free;
  logic                        rd_en;
  logic [IDXW-1:0]             rd_addr;
  logic [RECW-1:0]             rd_raw;
  entry_t                      rd_ent;
  logic                        wr_en;
  logic [IDXW-1:0]             wr_idx;
  entry_t                      wr_ent;
  logic                        set_vld, clr_vld, bump_order;
  logic                        emit, emit_last;
  pts_pkg::kind_t              emit_kind;
  logic [pts_pkg::HID_W-1:0]   emit_id;
  logic [pts_pkg::ARG_W-1:0]   emit_arg;
  logic                        due, decide_go, rescan;

  // Compare unit
  logic                        cur_vld, key_hit, better;
  logic [TW-1:0]               cur_age;

  pts_ram #(
    .WIDTH (RECW),
    .DEPTH (NUM_TIMERS)
  ) u_entries (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  assign rd_ent   = entry_t'(rd_raw);
  assign out_free = !rsp_vld_q || rsp.ready;
  assign accept   = req.valid && req.ready;

  // Shared compare: key match, free slot and head-of-queue ordering for one entry
  always_comb begin
    cur_vld = vld[cmp_idx];
    cur_age = order_cnt - rd_ent.order;
    key_hit = cur_vld && (rd_ent.handler == id_q) && (rd_ent.argument == arg_q);
    better  = cur_vld && (!best_found || (rd_ent.deadline < best.deadline) ||
              ((rd_ent.deadline == best.deadline) && (cur_age > best_age)));
  end

  // Tick decision: head entry is due and the per-tick fire budget is not spent
  assign due = best_found && (best.deadline <= now_clk) &&
               (fire_cnt < FIREW'(pts_pkg::MAX_RESULTS));

  always_comb begin
    if (op_q == pts_pkg::OP_TICK) begin
      decide_go = due ? (!hold_vld || out_free) : (!hold_vld || out_free);
    end else begin
      decide_go = out_free;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pts_pkg::ST_IDLE: begin
        if (accept && (req.op != pts_pkg::OP_RESERVED)) begin
          state_next = pts_pkg::ST_SCAN;
        end
      end
      pts_pkg::ST_SCAN: begin
        if ((scan_cnt == CNTW'(NUM_TIMERS)) && !cmp_vld) begin
          state_next = pts_pkg::ST_DECIDE;
        end
      end
      pts_pkg::ST_DECIDE: begin
        if (decide_go) begin
          state_next = rescan ? pts_pkg::ST_SCAN : pts_pkg::ST_IDLE;
        end
      end
      default: state_next = pts_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM access, valid bit updates, result load
  always_comb begin
    req.ready  = (state == pts_pkg::ST_IDLE);
    rd_en      = (state == pts_pkg::ST_SCAN) && (scan_cnt < CNTW'(NUM_TIMERS));
    rd_addr    = scan_cnt[IDXW-1:0];
    wr_en      = 1'b0;
    wr_idx     = best_idx;
    wr_ent     = best;
    set_vld    = 1'b0;
    clr_vld    = 1'b0;
    bump_order = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b1;
    emit_kind  = pts_pkg::KIND_FIRED;
    emit_id    = id_q;
    emit_arg   = arg_q;
    rescan     = 1'b0;
    if ((state == pts_pkg::ST_DECIDE) && decide_go) begin
      unique case (op_q)
        pts_pkg::OP_TICK: begin
          // Release the held fire; re-arm the head and sweep again if it is due
          emit      = hold_vld;
          emit_kind = pts_pkg::KIND_FIRED;
          emit_id   = hold_id;
          emit_arg  = hold_arg;
          emit_last = !due;
          if (due) begin
            rescan          = 1'b1;
            wr_en           = 1'b1;
            wr_idx          = best_idx;
            wr_ent          = best;
            wr_ent.deadline = best.deadline + TW'(best.period);
            wr_ent.order    = order_cnt;
            bump_order      = 1'b1;
          end
        end
        pts_pkg::OP_REGISTER: begin
          emit = 1'b1;
          if (bad_q) begin
            emit_kind = pts_pkg::KIND_BAD_INTERVAL;
          end else if (match_found || free_found) begin
            emit_kind       = pts_pkg::KIND_REGISTERED;
            wr_en           = 1'b1;
            wr_idx          = match_found ? match_idx : free_idx;
            wr_ent.handler  = id_q;
            wr_ent.argument = arg_q;
            wr_ent.period   = period_q;
            wr_ent.deadline = now_clk + TW'(period_q);
            wr_ent.order    = order_cnt;
            set_vld         = 1'b1;
            bump_order      = 1'b1;
          end else begin
            emit_kind = pts_pkg::KIND_FULL;
          end
        end
        pts_pkg::OP_UNREGISTER: begin
          emit = 1'b1;
          if (match_found) begin
            emit_kind = pts_pkg::KIND_REMOVED;
            clr_vld   = 1'b1;
          end else begin
            emit_kind = pts_pkg::KIND_NOT_FOUND;
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pts_pkg::ST_IDLE;
      now_clk     <= '0;
      order_cnt   <= '0;
      vld         <= '0;
      cmp_vld     <= 1'b0;
      scan_cnt    <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      best_found  <= 1'b0;
      fire_cnt    <= '0;
      hold_vld    <= 1'b0;
      rsp_vld_q   <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= rd_en;

      // Hold the result until taken
      if (emit) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld_q <= 1'b0;
      end

      // Start of a request: advance the clock on a tick and open a sweep
      if (accept) begin
        if (req.op == pts_pkg::OP_TICK) begin
          now_clk <= now_clk + 1'b1;
        end
        fire_cnt <= '0;
        hold_vld <= 1'b0;
      end

      if (accept || rescan) begin
        scan_cnt    <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        best_found  <= 1'b0;
      end else if (rd_en) begin
        scan_cnt <= scan_cnt + 1'b1;
      end

      // Compare stage flags
      if (cmp_vld) begin
        if (key_hit && !match_found) begin
          match_found <= 1'b1;
        end
        if (!cur_vld && !free_found) begin
          free_found <= 1'b1;
        end
        if (better) begin
          best_found <= 1'b1;
        end
      end

      // Fire bookkeeping
      if (rescan) begin
        fire_cnt <= fire_cnt + 1'b1;
        hold_vld <= 1'b1;
      end else if ((state == pts_pkg::ST_DECIDE) && decide_go) begin
        hold_vld <= 1'b0;
      end

      if (bump_order) begin
        order_cnt <= order_cnt + 1'b1;
      end
      if (set_vld) begin
        vld[wr_idx] <= 1'b1;
      end
      if (clr_vld) begin
        vld[match_idx] <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= req.op;
      id_q     <= req.handler_id;
      arg_q    <= req.handler_arg;
      period_q <= PERW'(32'(req.interval_sec) * 32'(TICKS_PER_SECOND));
      bad_q    <= (req.interval_sec == '0) ||
                  (req.interval_sec > pts_pkg::SEC_W'(pts_pkg::MAX_INTERVAL_SEC));
    end
    if (rd_en) begin
      cmp_idx <= rd_addr;
    end
    if (cmp_vld) begin
      if (key_hit && !match_found) begin
        match_idx <= cmp_idx;
      end
      if (!cur_vld && !free_found) begin
        free_idx <= cmp_idx;
      end
      if (better) begin
        best     <= rd_ent;
        best_idx <= cmp_idx;
        best_age <= cur_age;
      end
    end
    if (rescan) begin
      hold_id  <= best.handler;
      hold_arg <= best.argument;
    end
    if (emit) begin
      rsp_kind_q <= emit_kind;
      rsp_id_q   <= emit_id;
      rsp_arg_q  <= emit_arg;
      rsp_last_q <= emit_last;
    end
  end

  assign rsp.valid           = rsp_vld_q;
  assign rsp.kind            = rsp_kind_q;
  assign rsp.handler_id_res  = rsp_id_q;
  assign rsp.handler_arg_res = rsp_arg_q;
  assign rsp.last            = rsp_last_q;

endmodule

// ===== rtl/core/pts_checker.sv =====
// Port-level checks for the periodic timer scheduler, bound to the top level.
// Depends on pts_pkg and periodic_timer_scheduler_top.
module pts_sva (
  input logic                             clk,
  input logic                             rst,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [2:0]                       rsp_kind,
  input logic [pts_pkg::HID_W-1:0]        rsp_id,
  input logic [pts_pkg::ARG_W-1:0]        rsp_arg,
  input logic                             rsp_last
);

  // A stalled result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_id) &&
      $stable(rsp_arg) && $stable(rsp_last))
    else $error("result changed while stalled");

  // Only defined result codes leave the block
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_kind <= 3'(pts_pkg::KIND_NOT_FOUND))
    else $error("undefined result kind");

  // Register and unregister requests give exactly one result, so it is the last
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind != 3'(pts_pkg::KIND_FIRED)) |-> rsp_last)
    else $error("non-fire result not marked last");

  // Reset drops any pending result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind periodic_timer_scheduler_top pts_sva u_pts_sva (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_kind  (rsp.kind),
  .rsp_id    (rsp.handler_id_res),
  .rsp_arg   (rsp.handler_arg_res),
  .rsp_last  (rsp.last)
);

// ===== bench/pts_checker.sv =====
// Checker for the periodic timer scheduler: watches the request and result channels,
// keeps its own timer table, predicts every result and compares it field by field.
// Depends on pts_pkg and pts_if.
module pts_checker #(
  parameter int NUM_TIMERS       = 16,
  parameter int TICKS_PER_SECOND = 100
) (
  input  logic clk,
  input  logic rst,
  pts_req_if   req,
  pts_rsp_if   rsp,
  output int   error_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  typedef struct {
    kind_t            kind;
    logic [HID_W-1:0] hid;
    logic [ARG_W-1:0] harg;
    logic             last;
  } outcome_t;

  // Results predicted but not yet seen, oldest first
  outcome_t outcome_q[$];

  // Predicted timer table
  logic [TIME_W-1:0] now_ticks;
  logic [TIME_W-1:0] seq_count;
  logic              slot_live   [NUM_TIMERS];
  logic [HID_W-1:0]  slot_hid    [NUM_TIMERS];
  logic [ARG_W-1:0]  slot_arg    [NUM_TIMERS];
  logic [TIME_W-1:0] slot_period [NUM_TIMERS];
  logic [TIME_W-1:0] slot_due    [NUM_TIMERS];
  logic [TIME_W-1:0] slot_seq    [NUM_TIMERS];

  initial begin
    error_count = 0;
    pending     = 0;
  end

  function automatic outcome_t make_outcome(input kind_t kind, input logic [HID_W-1:0] hid,
                                            input logic [ARG_W-1:0] harg);
    outcome_t o;
    o.kind = kind;
    o.hid  = hid;
    o.harg = harg;
    o.last = 1'b0;
    return o;
  endfunction

  function automatic int find_slot(input logic [HID_W-1:0] hid, input logic [ARG_W-1:0] harg);
    int hit;
    hit = -1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (hit < 0 && slot_live[i] && slot_hid[i] == hid && slot_arg[i] == harg) hit = i;
    end
    return hit;
  endfunction

  // Earliest deadline wins; on a tie the oldest insertion wins
  function automatic int earliest_slot();
    int                best;
    logic [TIME_W-1:0] age_i;
    logic [TIME_W-1:0] age_b;
    best = -1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (slot_live[i]) begin
        if (best < 0) begin
          best = i;
        end else if (slot_due[i] < slot_due[best]) begin
          best = i;
        end else if (slot_due[i] == slot_due[best]) begin
          age_i = seq_count - slot_seq[i];
          age_b = seq_count - slot_seq[best];
          if (age_i > age_b) best = i;
        end
      end
    end
    return best;
  endfunction

  task automatic arm_slot(input int slot, input logic [TIME_W-1:0] due);
    slot_due[slot] = due;
    slot_seq[slot] = seq_count;
    seq_count      = seq_count + 1;
  endtask

  // Apply one accepted request to the table and queue the results it causes
  task automatic schedule_request(input op_t op, input logic [HID_W-1:0] hid,
                                  input logic [ARG_W-1:0] harg, input logic [SEC_W-1:0] sec);
    outcome_t          batch[$];
    int                slot;
    int                fired;
    bit                done;
    logic [TIME_W-1:0] period;
    case (op)
      OP_TICK: begin
        now_ticks = now_ticks + 1;
        fired     = 0;
        done      = 1'b0;
        while (!done && fired < MAX_RESULTS) begin
          slot = earliest_slot();
          if (slot < 0) begin
            done = 1'b1;
          end else if (slot_due[slot] > now_ticks) begin
            done = 1'b1;
          end else begin
            batch.push_back(make_outcome(KIND_FIRED, slot_hid[slot], slot_arg[slot]));
            arm_slot(slot, slot_due[slot] + slot_period[slot]);
            fired++;
          end
        end
      end
      OP_REGISTER: begin
        if (sec == 0 || sec > MAX_INTERVAL_SEC) begin
          batch.push_back(make_outcome(KIND_BAD_INTERVAL, hid, harg));
        end else begin
          slot = find_slot(hid, harg);
          // take the lowest free slot for a new key
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (slot < 0 && !slot_live[i]) slot = i;
          end
          if (slot < 0) begin
            batch.push_back(make_outcome(KIND_FULL, hid, harg));
          end else begin
            period            = TIME_W'(sec) * TIME_W'(TICKS_PER_SECOND);
            slot_live[slot]   = 1'b1;
            slot_hid[slot]    = hid;
            slot_arg[slot]    = harg;
            slot_period[slot] = period;
            arm_slot(slot, now_ticks + period);
            batch.push_back(make_outcome(KIND_REGISTERED, hid, harg));
          end
        end
      end
      OP_UNREGISTER: begin
        slot = find_slot(hid, harg);
        if (slot >= 0) begin
          slot_live[slot] = 1'b0;
          batch.push_back(make_outcome(KIND_REMOVED, hid, harg));
        end else begin
          batch.push_back(make_outcome(KIND_NOT_FOUND, hid, harg));
        end
      end
      default: begin
        // reserved op: no effect, no result
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) outcome_q.push_back(batch[i]);
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endtask

  // Check results first, then predict the request accepted at the same edge
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      now_ticks = '0;
      seq_count = '0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      outcome_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result with nothing pending: kind %0d, handler_id_res %0h, handler_arg_res %0h",
                 rsp.kind, rsp.handler_id_res, rsp.handler_arg_res);
          error_count++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("kind", 32'(want.kind), 32'(rsp.kind));
          compare_field("handler_id_res", 32'(want.hid), 32'(rsp.handler_id_res));
          compare_field("handler_arg_res", want.harg, rsp.handler_arg_res);
          compare_field("last", 32'(want.last), 32'(rsp.last));
        end
      end
      if (req.valid && req.ready) begin
        schedule_request(req.op, req.handler_id, req.handler_arg, req.interval_sec);
      end
    end
    pending = outcome_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the timer scheduler bench: clock, reset, request stimulus, result back-pressure,
// watchdog and verdict. Depends on pts_pkg, pts_if, pts_checker and the scheduler RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  localparam int NUM_TIMERS       = 16;
  localparam int TICKS_PER_SECOND = 100;
  localparam int KEY_POOL         = 24;
  localparam int PHASE_ITEMS      = 28;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = (NUM_TIMERS + 3) * 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int errors;
  int pending;
  int stall_cycles = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int phase_count  = 0;

  logic [HID_W-1:0] pool_hid [KEY_POOL];
  logic [ARG_W-1:0] pool_arg [KEY_POOL];

  pts_req_if req_ch ();
  pts_rsp_if rsp_ch ();

  periodic_timer_scheduler_top #(
    .NUM_TIMERS       (NUM_TIMERS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pts_checker #(
    .NUM_TIMERS       (NUM_TIMERS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .error_count (errors),
    .pending     (pending)
  );

  always #1 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("periodic_timer_scheduler_top test failed");
      $finish;
    end
  end

  // Present one request, idling first at random, and hold it until accepted
  task automatic issue(input op_t op, input logic [HID_W-1:0] hid,
                       input logic [ARG_W-1:0] harg, input logic [SEC_W-1:0] sec);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.handler_id   <= hid;
    req_ch.handler_arg  <= harg;
    req_ch.interval_sec <= sec;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    phase_count++;
  endtask

  // Drop valid and hold off until every predicted result has come back
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [SEC_W-1:0] pick_interval();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return SEC_W'($urandom_range(1, 3));
    if (roll < 80) return SEC_W'($urandom_range(1, MAX_INTERVAL_SEC));
    if (roll < 85) return '0;
    if (roll < 90) return SEC_W'($urandom_range(MAX_INTERVAL_SEC + 1, 131071));
    return SEC_W'($urandom());
  endfunction

  // Register, unregister or reserved op on a mostly pooled key
  task automatic random_request();
    int               roll;
    int               idx;
    logic [HID_W-1:0] hid;
    logic [ARG_W-1:0] harg;
    if ($urandom_range(0, 99) < 85) begin
      idx  = $urandom_range(0, KEY_POOL - 1);
      hid  = pool_hid[idx];
      harg = pool_arg[idx];
    end else begin
      hid  = HID_W'($urandom());
      harg = $urandom();
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      issue(OP_REGISTER, hid, harg, pick_interval());
    end else if (roll < 95) begin
      issue(OP_UNREGISTER, hid, harg, SEC_W'($urandom()));
    end else begin
      issue(OP_RESERVED, hid, harg, SEC_W'($urandom()));
    end
  endtask

  // A few table requests, then a short run of ticks with stray requests mixed in
  task automatic random_round();
    int n_ops;
    int n_burst;
    n_ops   = $urandom_range(1, 4);
    n_burst = $urandom_range(2, 10);
    repeat (n_ops) random_request();
    repeat (n_burst) begin
      if ($urandom_range(0, 99) < 8) begin
        random_request();
      end else begin
        issue(OP_TICK, HID_W'($urandom()), $urandom(), SEC_W'($urandom()));
      end
    end
    if ($urandom_range(0, 3) == 0) quiesce();
  endtask

  initial begin
    int               k;
    int               p;
    logic [ARG_W-1:0] harg;
    req_ch.valid        = 1'b0;
    req_ch.op           = OP_TICK;
    req_ch.handler_id   = '0;
    req_ch.handler_arg  = '0;
    req_ch.interval_sec = '0;
    rsp_ch.ready        = 1'b0;

    // key pool: extremes first, the rest random
    pool_hid[0] = 8'h00; pool_arg[0] = 32'h0000_0000;
    pool_hid[1] = 8'hFF; pool_arg[1] = 32'hFFFF_FFFF;
    pool_hid[2] = 8'h00; pool_arg[2] = 32'h8000_0000;
    pool_hid[3] = 8'hFF; pool_arg[3] = 32'h7FFF_FFFF;
    for (k = 4; k < KEY_POOL; k++) begin
      pool_hid[k] = HID_W'($urandom());
      pool_arg[k] = $urandom();
    end

    tx_idle_pct = 18;
    rx_idle_pct = 58;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unregister on an empty table
    issue(OP_UNREGISTER, 8'h00, 32'h0000_0000, '0);
    // bad intervals: zero, one past the maximum, all ones
    issue(OP_REGISTER, 8'hFF, 32'h8000_0000, '0);
    issue(OP_REGISTER, 8'h00, 32'h7FFF_FFFF, SEC_W'(MAX_INTERVAL_SEC + 1));
    issue(OP_REGISTER, 8'hFF, 32'h7FFF_FFFF, '1);
    // longest period, then a bad interval on the armed key, then re-arm in place
    issue(OP_REGISTER, 8'hA5, 32'h0000_0001, SEC_W'(MAX_INTERVAL_SEC));
    issue(OP_REGISTER, 8'hA5, 32'h0000_0001, '0);
    issue(OP_REGISTER, 8'hA5, 32'h0000_0001, SEC_W'(1));
    // fill the table with equal deadlines
    for (k = 1; k < NUM_TIMERS; k++) begin
      if (k == 1) harg = 32'h8000_0000;
      else if (k == 2) harg = 32'h7FFF_FFFF;
      else harg = $urandom();
      issue(OP_REGISTER, HID_W'(k * 17), harg, SEC_W'(1));
    end
    // new key on a full table, removal, reserved op
    issue(OP_REGISTER, 8'h5A, 32'hFFFF_FFFF, SEC_W'(2));
    issue(OP_UNREGISTER, 8'hA5, 32'h0000_0001, '0);
    issue(OP_RESERVED, 8'hFF, 32'hFFFF_FFFF, '1);
    quiesce();
    // advance to the shared deadline: all remaining timers fire on one tick
    repeat (TICKS_PER_SECOND + 2) issue(OP_TICK, '0, '0, '0);
    quiesce();

    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 18;
          rx_idle_pct = 58;
        end
        1: begin
          tx_idle_pct = 58;
          rx_idle_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) random_round();
    end

    // drain and give the verdict
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("periodic_timer_scheduler_top test passed");
    end else begin
      $display("periodic_timer_scheduler_top test failed");
    end
    $finish;
  end

endmodule
